>>> design/brc_pkg.sv
// Shared constants, state encoding and register indexes for the balance controller step.
// Used by brc_mul, brc_div and balance_robot_controller_step_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package brc_pkg;

	localparam int ENCODER_BITS = 32;

	localparam int MUL_AW = 50;
	localparam int MUL_BW = 16;
	localparam int MUL_PW = MUL_AW + MUL_BW;
	localparam int MUL_CW = $clog2(MUL_BW);

	localparam int DIV_NW = 20;
	localparam int DIV_DW = 10;
	localparam int DIV_CW = $clog2(DIV_NW);
	localparam logic [DIV_DW-1:0] DIVISOR = DIV_DW'(500);

	localparam int IN_W = 104;
	localparam int OUT_W = 24;
	localparam int ADDR_W = 5;

	localparam logic [2:0] REG_GYRO_BIAS = 3'd0;
	localparam logic [2:0] REG_GAIN_POSITION = 3'd1;
	localparam logic [2:0] REG_GAIN_VELOCITY = 3'd2;
	localparam logic [2:0] REG_GAIN_TILT = 3'd3;
	localparam logic [2:0] REG_GAIN_RATE = 3'd4;
	localparam logic [2:0] REG_GAIN_TURN = 3'd5;
	localparam logic [2:0] REG_GAIN_SYNC = 3'd6;
	localparam logic [2:0] REG_MOTOR_GAIN = 3'd7;

	localparam logic [7:0] SONAR_NEAR = 8'd30;
	localparam logic [12:0] AVOID_SAT = 13'd4095;
	localparam logic [11:0] AVOID_TIME = 12'd2500;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TILT,
		ST_DIV,
		ST_MEAN1,
		ST_MEAN2,
		ST_MEAN3,
		ST_DIFF,
		ST_PTILT,
		ST_PRATE,
		ST_PPOS,
		ST_PVEL,
		ST_PWR,
		ST_BASE,
		ST_SYNC,
		ST_OUT,
		ST_DONE
	} brc_state_t;

endpackage
`default_nettype wire

>>> design/brc_mul.sv
// Bit-serial sign-magnitude multiplier: one multiplier bit per cycle, shift-add accumulate.
// Depends on brc_pkg for operand and product widths.
`timescale 1ns / 1ps
`default_nettype none
module brc_mul
	import brc_pkg::*;
(
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	input  wire signed [MUL_AW-1:0]  a,
	input  wire        [MUL_BW-1:0]  b,
	output logic                     done,
	output logic                     neg,
	output logic       [MUL_PW-1:0]  prod
);

	logic [MUL_AW+MUL_BW:0] p_q;
	logic [MUL_AW-1:0]      a_q;
	logic                   neg_q;
	logic [MUL_CW-1:0]      cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [MUL_AW:0]        sum;

	always_comb begin
		sum = p_q[MUL_AW+MUL_BW:MUL_BW] + (p_q[0] ? {1'b0, a_q} : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MUL_CW'(MUL_BW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a[MUL_AW-1] ? MUL_AW'(-a) : MUL_AW'(a);
			neg_q <= a[MUL_AW-1];
			p_q <= {(MUL_AW+1)'(0), b};
		end else if (busy_q) begin
			p_q <= {1'b0, sum, p_q[MUL_BW-1:1]};
		end
	end

	assign done = done_q;
	assign neg = neg_q;
	assign prod = p_q[MUL_PW-1:0];

endmodule
`default_nettype wire

>>> design/brc_div.sv
// Restoring serial divider by the constant 500, one quotient bit per cycle.
// Depends on brc_pkg for the dividend width and the divisor.
`timescale 1ns / 1ps
`default_nettype none
module brc_div
	import brc_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire  [DIV_NW-1:0] n,
	output logic              done,
	output logic [DIV_NW-1:0] quot
);

	logic [DIV_NW-1:0] n_q;
	logic [DIV_DW-2:0] rem_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW-1:0] r;
	logic              ge;

	always_comb begin
		r = {rem_q, n_q[DIV_NW-1]};
		ge = (r >= DIVISOR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= n;
			rem_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[DIV_NW-2:0], ge};
			rem_q <= ge ? (DIV_DW-1)'(r - DIVISOR) : r[DIV_DW-2:0];
		end
	end

	assign done = done_q;
	assign quot = n_q;

endmodule
`default_nettype wire

>>> design/balance_robot_controller_step_top.sv
// Two-wheel balance controller step: one control period per input item.
// Depends on brc_pkg, brc_mul and brc_div.
//
// Usage: the s_ group takes one item per control period (gyro samples, elapsed
// time, both wheel encoder counts and the sonar distance). The m_ group gives one
// result item per input item: both saturated motor drives and the avoidance flag.
// The APB port sets the gyro bias and the gains; write it only while no item is
// in flight.
// Seven products go one after the other through a single bit-serial
// multiplier, and the tilt increment goes through a serial divider by 500.
// One item is in work at a time: a new item is taken only after the last
// result has been loaded into the output register.
// s_tready is high whenever the sequencer is idle, also while a finished result
// still waits in the output register. If the receiver stalls, the next item is
// worked on and then holds until the output register frees.
// Reset clears all controller state and loads the register reset values.
`timescale 1ns / 1ps
`default_nettype none
module balance_robot_controller_step_top
	import brc_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_tvalid,
	output logic              s_tready,
	// gyro_mid, gyro_end, elapsed_ms, encoder_a, encoder_c, sonar_distance, zero pad
	input  wire  [IN_W-1:0]   s_tdata,
	output logic              m_tvalid,
	input  wire               m_tready,
	// motor_a_drive, motor_c_drive, avoiding_now, zero pad
	output logic [OUT_W-1:0]  m_tdata,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire  [ADDR_W-1:0] paddr,
	input  wire  [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	function automatic logic signed [8:0] gyro_rate(input logic [9:0] raw,
			input logic [13:0] bias);
		logic signed [15:0] d;
		logic signed [15:0] t;
		d = $signed({2'b00, raw, 4'b0000}) - $signed({2'b00, bias});
		t = d[15] ? (d + 16'sd63) : d;
		gyro_rate = t[14:6];
	endfunction

	function automatic logic signed [31:0] enc_value(input logic [31:0] raw);
		logic [31:0] r;
		for (int i = 0; i < 32; i++) begin
			r[i] = (i < ENCODER_BITS) ? raw[i] : raw[ENCODER_BITS-1];
		end
		enc_value = $signed(r);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [55:0] x);
		if (x > 56'sh0000_007FFF_FFFF) begin
			sat32 = 32'sh7FFF_FFFF;
		end else if (x < -56'sh0000_0080_0000_00) begin
			sat32 = -32'sh8000_0000;
		end else begin
			sat32 = x[31:0];
		end
	endfunction

	function automatic logic signed [55:0] apply_sign(input logic neg,
			input logic [55:0] mag);
		apply_sign = neg ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic logic [7:0] drive8(input logic signed [55:0] n);
		logic signed [55:0] t;
		t = n[55] ? ((n + 56'sd255) >>> 8) : (n >>> 8);
		if (t > 56'sd100) begin
			drive8 = 8'd100;
		end else if (t < -56'sd100) begin
			drive8 = 8'(-8'sd100);
		end else begin
			drive8 = t[7:0];
		end
	endfunction

	logic [13:0] gyro_bias_q;
	logic [15:0] gain_position_q;
	logic [15:0] gain_velocity_q;
	logic [15:0] gain_tilt_q;
	logic [15:0] gain_rate_q;
	logic [15:0] gain_turn_q;
	logic [15:0] gain_sync_q;
	logic [15:0] motor_gain_q;

	logic signed [31:0] tilt_q;
	logic signed [47:0] mean_q;
	logic signed [8:0]  rate_prev_q;
	logic signed [31:0] wheel_pos_prev_q;
	logic               avoid_active_q;
	logic [11:0]        avoid_elapsed_q;
	logic signed [31:0] wheel_offset_q;

	logic signed [10:0] m_q;
	logic [9:0]         dt_q;
	logic signed [8:0]  rate_end_q;
	logic signed [31:0] enc_a_q;
	logic signed [31:0] enc_c_q;
	logic signed [33:0] v_q;
	logic signed [33:0] e_q;
	logic               av_q;
	logic [DIV_NW-1:0]  tprod_q;
	logic               tneg_q;
	logic signed [57:0] dlt_q;
	logic signed [55:0] sacc_q;
	logic signed [31:0] pwr_q;
	logic signed [55:0] na_q;
	logic signed [55:0] nc_q;
	logic [7:0]         da_q;
	logic [7:0]         dc_q;
	logic               phase_q;

	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;

	brc_state_t state_q;
	brc_state_t state_d;

	logic                     mul_start;
	logic signed [MUL_AW-1:0] mul_a;
	logic [MUL_BW-1:0]        mul_b;
	logic                     mul_done;
	logic                     mul_neg;
	logic [MUL_PW-1:0]        mul_prod;
	logic                     div_start;
	logic                     div_done;
	logic [DIV_NW-1:0]        div_quot;

	logic               accept;
	logic               cfg_wr;
	logic               out_load;
	logic signed [8:0]  rate_mid;
	logic signed [8:0]  rate_end;
	logic signed [31:0] enc_a;
	logic signed [31:0] enc_c;
	logic signed [10:0] rm_x;
	logic signed [32:0] xm1;
	logic               av_next;
	logic [11:0]        el_next;
	logic               to_load;
	logic [12:0]        el_sum;

	brc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.neg    (mul_neg),
		.prod   (mul_prod)
	);

	brc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (tprod_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_bias_q <= 14'd9608;
			gain_position_q <= 16'd0;
			gain_velocity_q <= 16'd23040;
			gain_tilt_q <= 16'd2048;
			gain_rate_q <= 16'd2560;
			gain_turn_q <= 16'd4096;
			gain_sync_q <= 16'd1664;
			motor_gain_q <= 16'd179;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_GYRO_BIAS:     gyro_bias_q <= pwdata[13:0];
				REG_GAIN_POSITION: gain_position_q <= pwdata[15:0];
				REG_GAIN_VELOCITY: gain_velocity_q <= pwdata[15:0];
				REG_GAIN_TILT:     gain_tilt_q <= pwdata[15:0];
				REG_GAIN_RATE:     gain_rate_q <= pwdata[15:0];
				REG_GAIN_TURN:     gain_turn_q <= pwdata[15:0];
				REG_GAIN_SYNC:     gain_sync_q <= pwdata[15:0];
				REG_MOTOR_GAIN:    motor_gain_q <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_GYRO_BIAS:     prdata = 32'(gyro_bias_q);
			REG_GAIN_POSITION: prdata = 32'(gain_position_q);
			REG_GAIN_VELOCITY: prdata = 32'(gain_velocity_q);
			REG_GAIN_TILT:     prdata = 32'(gain_tilt_q);
			REG_GAIN_RATE:     prdata = 32'(gain_rate_q);
			REG_GAIN_TURN:     prdata = 32'(gain_turn_q);
			REG_GAIN_SYNC:     prdata = 32'(gain_sync_q);
			REG_MOTOR_GAIN:    prdata = 32'(motor_gain_q);
		endcase
	end

	// Input decode and the avoidance timer, which needs this item's fields and the stored timer state.
	always_comb begin
		rate_mid = gyro_rate(s_tdata[9:0], gyro_bias_q);
		rate_end = gyro_rate(s_tdata[19:10], gyro_bias_q);
		enc_a = enc_value(s_tdata[61:30]);
		enc_c = enc_value(s_tdata[93:62]);
		rm_x = 11'(rate_mid);
		xm1 = 33'(enc_c) + ~33'(wheel_pos_prev_q);
		av_next = avoid_active_q;
		el_next = avoid_elapsed_q;
		to_load = 1'b0;
		el_sum = 13'(avoid_elapsed_q) + 13'(s_tdata[29:20]);
		if (avoid_active_q) begin
			el_next = (el_sum > AVOID_SAT) ? AVOID_SAT[11:0] : el_sum[11:0];
		end
		if ((s_tdata[101:94] < SONAR_NEAR) && !avoid_active_q) begin
			av_next = 1'b1;
			el_next = '0;
		end
		if (av_next && (el_next > AVOID_TIME)) begin
			av_next = 1'b0;
			to_load = 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_TILT;
			ST_TILT:  if (phase_q && mul_done) state_d = ST_DIV;
			ST_DIV:   if (phase_q && div_done) state_d = ST_MEAN1;
			ST_MEAN1: state_d = ST_MEAN2;
			ST_MEAN2: state_d = ST_MEAN3;
			ST_MEAN3: state_d = ST_DIFF;
			ST_DIFF:  state_d = ST_PTILT;
			ST_PTILT: if (phase_q && mul_done) state_d = ST_PRATE;
			ST_PRATE: if (phase_q && mul_done) state_d = ST_PPOS;
			ST_PPOS:  if (phase_q && mul_done) state_d = ST_PVEL;
			ST_PVEL:  if (phase_q && mul_done) state_d = ST_PWR;
			ST_PWR:   state_d = ST_BASE;
			ST_BASE:  if (phase_q && mul_done) state_d = ST_SYNC;
			ST_SYNC:  if (phase_q && mul_done) state_d = ST_OUT;
			ST_OUT:   state_d = ST_DONE;
			ST_DONE:  if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		mul_a = '0;
		mul_b = '0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_TILT: begin
				mul_start = !phase_q;
				mul_a = MUL_AW'(m_q);
				mul_b = MUL_BW'(dt_q);
			end
			ST_DIV: div_start = !phase_q;
			ST_PTILT: begin
				mul_start = !phase_q;
				mul_a = dlt_q[MUL_AW-1:0];
				mul_b = gain_tilt_q;
			end
			ST_PRATE: begin
				mul_start = !phase_q;
				mul_a = MUL_AW'(rate_end_q);
				mul_b = gain_rate_q;
			end
			ST_PPOS: begin
				mul_start = !phase_q;
				mul_a = MUL_AW'(enc_c_q);
				mul_b = gain_position_q;
			end
			ST_PVEL: begin
				mul_start = !phase_q;
				mul_a = MUL_AW'(v_q);
				mul_b = gain_velocity_q;
			end
			ST_BASE: begin
				mul_start = !phase_q;
				mul_a = MUL_AW'(pwr_q);
				mul_b = motor_gain_q;
			end
			ST_SYNC: begin
				mul_start = !phase_q;
				mul_a = MUL_AW'(e_q);
				mul_b = av_q ? '0 : gain_sync_q;
			end
			ST_DONE: out_load = !m_tvalid_q || m_tready;
			default: begin
			end
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			tilt_q <= '0;
			mean_q <= '0;
			rate_prev_q <= '0;
			wheel_pos_prev_q <= '0;
			avoid_active_q <= 1'b0;
			avoid_elapsed_q <= '0;
			wheel_offset_q <= '0;
		end else begin
			state_q <= state_d;
			if (mul_start || div_start) begin
				phase_q <= 1'b1;
			end else if (mul_done || div_done) begin
				phase_q <= 1'b0;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (accept) begin
				rate_prev_q <= rate_end;
				wheel_pos_prev_q <= enc_c;
				avoid_active_q <= av_next;
				avoid_elapsed_q <= el_next;
				if (to_load) begin
					wheel_offset_q <= enc_a - enc_c;
				end
			end
			if (state_q == ST_DIV && phase_q && div_done) begin
				tilt_q <= sat32(56'(tilt_q) + 56'(tneg_q ? -$signed(12'(div_quot))
					: $signed(12'(div_quot))));
			end
			if (state_q == ST_MEAN3) begin
				mean_q <= mean_q + 48'(dlt_q >>> 16);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_q <= 11'(rate_prev_q) + (rm_x <<< 1);
			dt_q <= s_tdata[29:20];
			rate_end_q <= rate_end;
			enc_a_q <= enc_a;
			enc_c_q <= enc_c;
			v_q <= $signed({xm1, 1'b1});
			av_q <= av_next;
		end
		unique case (state_q)
			ST_TILT: begin
				e_q <= 34'(enc_a_q) - 34'(enc_c_q) - 34'(wheel_offset_q);
				if (phase_q && mul_done) begin
					tprod_q <= mul_prod[DIV_NW-1:0];
					tneg_q <= mul_neg;
				end
			end
			ST_MEAN1, ST_DIFF: dlt_q <= (58'(tilt_q) <<< 16) - 58'(mean_q);
			ST_MEAN2: dlt_q <= (dlt_q <<< 6) + (dlt_q <<< 1);
			ST_PTILT: if (phase_q && mul_done) begin
				sacc_q <= apply_sign(mul_neg, 56'({mul_prod[MUL_PW-1:24], 9'b0}));
			end
			ST_PRATE: if (phase_q && mul_done) begin
				sacc_q <= sacc_q + apply_sign(mul_neg, 56'({mul_prod[46:8], 9'b0}));
			end
			ST_PPOS: if (phase_q && mul_done) begin
				sacc_q <= sacc_q + apply_sign(mul_neg, {mul_prod[54:0], 1'b0});
			end
			ST_PVEL: if (phase_q && mul_done) begin
				sacc_q <= sacc_q + apply_sign(mul_neg, mul_prod[55:0]);
			end
			ST_PWR: pwr_q <= sat32(sacc_q[55] ? ((sacc_q + 56'sd511) >>> 9)
				: (sacc_q >>> 9));
			ST_BASE: if (phase_q && mul_done) begin
				na_q <= apply_sign(mul_neg, mul_prod[55:0])
					- (av_q ? 56'(gain_turn_q) : 56'sd0);
				nc_q <= apply_sign(mul_neg, mul_prod[55:0])
					+ (av_q ? 56'(gain_turn_q) : 56'sd0);
			end
			ST_SYNC: if (phase_q && mul_done) begin
				na_q <= na_q - apply_sign(mul_neg, mul_prod[55:0]);
			end
			ST_OUT: begin
				da_q <= drive8(na_q);
				dc_q <= drive8(nc_q);
			end
			default: begin
			end
		endcase
		if (out_load) begin
			m_tdata_q <= {7'b0, av_q, dc_q, da_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

`ifndef SYNTH
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !$rose(m_tvalid))
		else $error("result appeared directly after an accept");
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (($signed(m_tdata[7:0]) >= -8'sd100)
			&& ($signed(m_tdata[7:0]) <= 8'sd100)
			&& ($signed(m_tdata[15:8]) >= -8'sd100)
			&& ($signed(m_tdata[15:8]) <= 8'sd100)))
		else $error("motor drive out of range");
	a_hold_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && m_tvalid && !m_tready |=> (state_q == ST_DONE))
		else $error("finished result dropped while output stalled");
`endif

endmodule
`default_nettype wire
